/* design/mei_pkg.sv */
// ----------------------------------------------------------------------------
// Manchester edge-interval receiver package
// Shared payload types, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package mei_pkg;

    // Default width of the received bit shift register.
    localparam int FRAME_WIDTH_DEF = 16;

    // Width of the frame field in a result.
    localparam int FRAME_OUT_W = 16;

    // Configuration register indexes.
    localparam logic [1:0] CFG_GAP_THRESHOLD   = 2'd0;
    localparam logic [1:0] CFG_LONG_THRESHOLD  = 2'd1;
    localparam logic [1:0] CFG_READY_HALF_BITS = 2'd2;

    // Configuration reset values.
    localparam logic [31:0] GAP_THRESHOLD_RST   = 32'd200000;
    localparam logic [31:0] LONG_THRESHOLD_RST  = 32'd105000;
    localparam logic [7:0]  READY_HALF_BITS_RST = 8'd17;

    // Item modes.
    localparam logic MODE_EDGE = 1'b0;
    localparam logic MODE_TAKE = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [31:0] edge_time;
    } mei_in_t;

    typedef struct packed {
        logic [FRAME_OUT_W-1:0] frame;
        logic                   ready_res;
        logic                   taken;
    } mei_out_t;

    typedef struct packed {
        logic [31:0] gap_threshold;
        logic [31:0] long_threshold;
        logic [7:0]  ready_half_bits;
    } mei_cfg_t;

endpackage

/* design/mei_in_stage.sv */
// ----------------------------------------------------------------------------
// Manchester receiver input register
// Holds one accepted item until the decoder can pass its result on.
// ----------------------------------------------------------------------------
module mei_in_stage
    import mei_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  mei_in_t in_data,
    input  logic    out_space,
    output logic    item_valid,
    output mei_in_t item,
    output logic    advance
);

    logic    valid_reg;
    mei_in_t data_reg;
    logic    load;

    // The held item moves on whenever the result register has room.
    assign advance  = valid_reg && out_space;
    assign in_ready = !valid_reg || advance;
    assign load     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= in_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = data_reg;

endmodule

/* design/mei_core.sv */
// ----------------------------------------------------------------------------
// Manchester receiver decode core
// Classifies an edge interval and updates the frame state, or takes a ready frame, for one transfer.
// ----------------------------------------------------------------------------
module mei_core
    import mei_pkg::*;
#(
    parameter int FRAME_WIDTH = FRAME_WIDTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  mei_cfg_t cfg,
    input  logic     advance,
    input  mei_in_t  item,
    output mei_out_t result
);

    logic [31:0]            prev_time_reg,  prev_time_next;
    logic [FRAME_WIDTH-1:0] shift_reg,      shift_next;
    logic [7:0]             count_reg,      count_next;
    logic                   held_reg,       held_next;
    logic                   ready_reg,      ready_next;

    logic [31:0] interval;
    logic        is_gap;
    logic        is_long;
    logic        took;

    assign interval = item.edge_time - prev_time_reg;
    assign is_gap   = interval > cfg.gap_threshold;
    assign is_long  = interval > cfg.long_threshold;

    always_comb
    begin
        prev_time_next = prev_time_reg;
        shift_next     = shift_reg;
        count_next     = count_reg;
        held_next      = held_reg;
        ready_next     = ready_reg;
        took           = 1'b0;

        if (item.mode == MODE_EDGE)
        begin
            if (is_gap)
            begin
                shift_next = '0;
                count_next = '0;
                held_next  = 1'b1;
                ready_next = 1'b0;
            end
            else if (is_long)
            begin
                held_next  = !held_reg;
                shift_next = {shift_reg[FRAME_WIDTH-2:0], !held_reg};
                count_next = count_reg + 8'd2;
            end
            else
            begin
                count_next = count_reg + 8'd1;
                // The count turns odd exactly when it was even before.
                if (!count_reg[0])
                begin
                    shift_next = {shift_reg[FRAME_WIDTH-2:0], held_reg};
                end
            end

            if (count_next >= cfg.ready_half_bits)
            begin
                ready_next = 1'b1;
            end
            prev_time_next = item.edge_time;
        end
        else if (ready_reg)
        begin
            ready_next = 1'b0;
            took       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_time_reg <= '0;
            shift_reg     <= '0;
            count_reg     <= '0;
            held_reg      <= 1'b1;
            ready_reg     <= 1'b0;
        end
        else if (advance)
        begin
            prev_time_reg <= prev_time_next;
            shift_reg     <= shift_next;
            count_reg     <= count_next;
            held_reg      <= held_next;
            ready_reg     <= ready_next;
        end
    end

    assign result.frame     = FRAME_OUT_W'(shift_next);
    assign result.ready_res = ready_next;
    assign result.taken     = took;

endmodule

/* design/mei_out_stage.sv */
// ----------------------------------------------------------------------------
// Manchester receiver result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module mei_out_stage
    import mei_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     advance,
    input  mei_out_t result,
    output logic     out_space,
    output logic     out_valid,
    input  logic     out_ready,
    output mei_out_t out_data
);

    logic     valid_reg;
    mei_out_t data_reg;

    assign out_space = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* design/manchester_edge_interval_receiver.sv */
// ----------------------------------------------------------------------------
// Manchester edge-interval receiver
// Decodes a Manchester line from edge timestamps and hands out frames.
// ----------------------------------------------------------------------------
// Usage:
// Each transfer on the input channel is either an edge, carrying the value of
// a free-running cycle counter, or a take request. Every input transfer gives
// exactly one result transfer carrying the frame, the ready flag and whether
// a ready frame was taken.
// The configuration port writes the gap threshold, the long-interval
// threshold and the ready half-bit count; the user must see that it is
// written only while idle, as the block does not enforce this. An item waits
// in the input register until its result can move into the result register.
// Throughput is one item per cycle while the result side takes results;
// each update is a 32-bit interval subtract and compare, then an 8-bit count.
// When the receiver stalls, the result register holds its result and the
// input register can still take one more item; the input side then stalls.
// Reset clears both registers, the frame state and the ready flag, sets the
// held bit to one and loads the configuration reset values.
// ----------------------------------------------------------------------------
module manchester_edge_interval_receiver
    import mei_pkg::*;
#(
    parameter int FRAME_WIDTH = FRAME_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  mei_in_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output mei_out_t    out_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    // Configuration registers. A write to an index beyond the list is dropped.
    mei_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gap_threshold   <= GAP_THRESHOLD_RST;
            cfg_reg.long_threshold  <= LONG_THRESHOLD_RST;
            cfg_reg.ready_half_bits <= READY_HALF_BITS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GAP_THRESHOLD:   cfg_reg.gap_threshold   <= cfg_data;
                CFG_LONG_THRESHOLD:  cfg_reg.long_threshold  <= cfg_data;
                CFG_READY_HALF_BITS: cfg_reg.ready_half_bits <= cfg_data[7:0];
                default:             ;
            endcase
        end
    end

    logic     out_space;
    logic     item_valid;
    mei_in_t  item;
    logic     advance;
    mei_out_t result;

    // The input register parts the two channels so that a waiting result
    // does not stop the next transfer from being taken in.
    mei_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_space  (out_space),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance)
    );

    // The frame state moves only when the held item is passed on.
    mei_core #(
        .FRAME_WIDTH (FRAME_WIDTH)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .advance (advance),
        .item    (item),
        .result  (result)
    );

    mei_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .result    (result),
        .out_space (out_space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // A take clears the ready flag, so a result never shows both at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.taken && out_data.ready_res))
        else $error("taken and ready_res both set in one result");

    // A held item with an empty result register always moves on.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !out_valid) |=> out_valid)
        else $error("held item did not reach the result register");

    // While the result side stalls, the held item stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && out_valid && !out_ready) |=> (item_valid && $stable(item)))
        else $error("held item lost during a stall");

endmodule

/* tb/manchester_edge_interval_receiver_tb.sv */
// ----------------------------------------------------------------------------
// Manchester edge-interval receiver testbench
// Sends edge and take requests to the receiver, predicts the frame, the ready
// flag and the taken flag of every result transfer, and compares each result
// with the oldest prediction. The run goes through several threshold settings,
// the extremes among them, with random stalls on both channels.
// ----------------------------------------------------------------------------
module manchester_edge_interval_receiver_tb;

    import mei_pkg::*;

    // Width of the shift register in the block and in the prediction.
    localparam int FRAME_W = FRAME_WIDTH_DEF;

    // Cycles without any transfer on either channel before the run is given up.
    localparam int QUIET_LIMIT = 2000;

    // Cycles allowed after the last result before a register write or the end of the run.
    localparam int SETTLE_CYCLES = 4;

    // ------------------------------------------------------------------------
    // Scoreboard. It keeps its own copy of the thresholds and of the frame
    // state, works out the result of every accepted item, and compares the
    // results of the block with those predictions in order.
    // ------------------------------------------------------------------------
    class frame_scoreboard;
        logic [31:0]        gap_limit;
        logic [31:0]        long_limit;
        logic [7:0]         ready_count;
        logic [31:0]        last_edge;
        logic [FRAME_W-1:0] shift_reg;
        logic [7:0]         half_bits;
        logic               held;
        logic               frame_waiting;
        mei_out_t           expected_q[$];
        int                 errors;

        function new();
            gap_limit     = GAP_THRESHOLD_RST;
            long_limit    = LONG_THRESHOLD_RST;
            ready_count   = READY_HALF_BITS_RST;
            last_edge     = '0;
            shift_reg     = '0;
            half_bits     = '0;
            held          = 1'b1;
            frame_waiting = 1'b0;
            errors        = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void set_register(logic [1:0] index, logic [31:0] value);
            case (index)
                CFG_GAP_THRESHOLD:   gap_limit = value;
                CFG_LONG_THRESHOLD:  long_limit = value;
                CFG_READY_HALF_BITS: ready_count = value[7:0];
                default: ;
            endcase
        endfunction

        // Note an accepted input transfer and queue the result it must give.
        function void note_item(mei_in_t item);
            logic [31:0] span;
            mei_out_t    result;
            result.taken = 1'b0;
            if (item.mode == MODE_EDGE)
            begin
                // The interval wraps with the free-running counter.
                span = item.edge_time - last_edge;
                if (span > gap_limit)
                begin
                    shift_reg     = '0;
                    frame_waiting = 1'b0;
                    half_bits     = '0;
                    held          = 1'b1;
                end
                else if (span > long_limit)
                begin
                    held      = ~held;
                    shift_reg = {shift_reg[FRAME_W-2:0], held};
                    half_bits = half_bits + 8'd2;
                end
                else
                begin
                    half_bits = half_bits + 8'd1;
                    if (half_bits[0])
                        shift_reg = {shift_reg[FRAME_W-2:0], held};
                end
                // The ready test runs on every edge, a frame restart included.
                if (half_bits >= ready_count)
                    frame_waiting = 1'b1;
                last_edge = item.edge_time;
            end
            else if (frame_waiting)
            begin
                frame_waiting = 1'b0;
                result.taken  = 1'b1;
            end
            result.frame     = shift_reg[FRAME_OUT_W-1:0];
            result.ready_res = frame_waiting;
            expected_q.push_back(result);
        endfunction

        task report_mismatch(string what);
            if (errors < 100)
                $display("mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        // Compare one accepted result transfer with the oldest prediction.
        task check_result(mei_out_t got);
            mei_out_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("result frame=%h ready=%b taken=%b with none due",
                                          got.frame, got.ready_res, got.taken));
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.frame !== want.frame)
                    report_mismatch($sformatf("frame %h, predicted %h",
                                              got.frame, want.frame));
                if (got.ready_res !== want.ready_res)
                    report_mismatch($sformatf("ready %b, predicted %b",
                                              got.ready_res, want.ready_res));
                if (got.taken !== want.taken)
                    report_mismatch($sformatf("taken %b, predicted %b",
                                              got.taken, want.taken));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals of the block. Every input has a known value from time zero.
    // ------------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    mei_in_t     in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    mei_out_t    out_data;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_GAP_THRESHOLD;
    logic [31:0] cfg_data = '0;

    frame_scoreboard sb = new();

    // Time of the last edge sent, so that intervals can be chosen per class.
    logic [31:0] last_edge_sent = '0;

    // While set, neither side idles: a long stretch at full rate.
    bit calm = 1'b0;

    int quiet_cycles = 0;

    manchester_edge_interval_receiver #(
        .FRAME_WIDTH(FRAME_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Period of 8 time units.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Result side. Signals are sampled just after the rising edge, before any
    // register of the block has taken its new value, so a transfer is seen
    // exactly at the edge where valid and ready were both high. Ready then
    // drops with a chance of about 8 in a hundred, except during the calm stretch.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result(out_data);
            out_ready <= calm || ($urandom_range(99) >= 8);
        end
    end

    // Watchdog: a hung handshake shows up as a long run of cycles with no
    // transfer on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Input side.
    // ------------------------------------------------------------------------

    // Offer one item and hold it until the transfer happens. Valid is only
    // lowered before an idle gap, so it never falls and rises in one step.
    task automatic send_item(mei_in_t item);
        if (!calm && $urandom_range(99) < 8)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(2, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_item(item);
    endtask

    task automatic edge_at(logic [31:0] stamp);
        mei_in_t item;
        item.mode      = MODE_EDGE;
        item.edge_time = stamp;
        last_edge_sent = stamp;
        send_item(item);
    endtask

    task automatic edge_after(logic [31:0] interval);
        edge_at(last_edge_sent + interval);
    endtask

    // A take request carries a random time, which the block must ignore.
    task automatic send_take();
        mei_in_t item;
        item.mode      = MODE_TAKE;
        item.edge_time = $urandom;
        send_item(item);
    endtask

    // Choose an interval for the next edge from the current thresholds:
    // a gap in about gap_pct of a hundred, a full bit period in about 45,
    // otherwise a half-bit, with the class boundaries hit often. A class
    // that the thresholds leave empty falls through to the next one.
    function automatic logic [31:0] pick_interval(int gap_pct);
        logic [31:0] g;
        logic [31:0] l;
        logic [31:0] short_top;
        int          r;
        g = sb.gap_limit;
        l = sb.long_limit;
        short_top = (l < g) ? l : g;
        r = $urandom_range(99);
        if (r < gap_pct && g != 32'hFFFF_FFFF)
        begin
            if ($urandom_range(3) == 0)
                return g + 32'd1;
            return g + 32'd1 + ($urandom % (32'hFFFF_FFFF - g));
        end
        if (r < gap_pct + 45 && l < g)
        begin
            case ($urandom_range(5))
                0: return l + 32'd1;
                1: return g;
                default: return l + 32'd1 + ($urandom % (g - l));
            endcase
        end
        case ($urandom_range(5))
            0: return short_top;
            1: return 32'd0;
            default: return 32'(33'($urandom) % ({1'b0, short_top} + 33'd1));
        endcase
    endfunction

    // Mostly well-formed edge streams, some take requests, and a little noise
    // in the form of edges at a completely random time.
    task automatic run_random(int count, int gap_pct, int take_pct);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < take_pct)
                send_take();
            else if ($urandom_range(99) < 3)
                edge_at($urandom);
            else
                edge_after(pick_interval(gap_pct));
        end
    endtask

    // Stop offering items and wait until every predicted result has arrived,
    // then let the pipeline settle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write enable stays high across back-to-back writes and is lowered
    // once after the last of them.
    task automatic write_reg(logic [1:0] index, logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        sb.set_register(index, value);
    endtask

    task automatic configure(logic [31:0] gap, logic [31:0] long_bit, logic [7:0] ready);
        wait_idle();
        write_reg(CFG_GAP_THRESHOLD, gap);
        write_reg(CFG_LONG_THRESHOLD, long_bit);
        write_reg(CFG_READY_HALF_BITS, {24'd0, ready});
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        logic [31:0] gap;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with the reset thresholds (gap 200000, long 105000,
        // ready at 17 half-bits).
        // A take with nothing ready changes nothing; its time field is junk.
        send_take();
        edge_after(32'd0);          // zero interval counts as a half-bit
        edge_after(32'd105000);     // exactly on the long threshold: still short
        edge_after(32'd105001);     // just above it: a full bit period
        edge_after(32'd200000);     // exactly on the gap threshold: still long
        edge_after(32'd200001);     // just above it: the frame restarts
        repeat (9) edge_after(32'd150000);  // 18 half-bits, so ready is set
        send_take();                // takes the ready frame
        send_take();                // nothing left to take
        edge_after(32'd50000);      // count is still high, so ready comes back
        edge_at(32'hFFFF_FFF0);     // large jump: a gap
        edge_at(32'h0000_0010);     // the counter wrapped: a short interval
        send_take();

        run_random(300, 5, 15);

        // No gap is possible and every non-zero interval is a full bit, so
        // the half-bit count runs past 255 and wraps.
        configure(32'hFFFF_FFFF, 32'd0, 8'd255);
        run_random(200, 0, 8);

        // Ready threshold of zero, so every edge marks the frame ready; this
        // phase also runs with no idling on either side.
        configure(32'd1000, 32'd400, 8'd0);
        calm = 1'b1;
        run_random(150, 6, 20);
        calm = 1'b0;

        // Every non-zero interval is a gap and the long class is empty.
        configure(32'd0, 32'hFFFF_FFFF, 8'd1);
        run_random(100, 50, 20);

        repeat (4)
        begin
            gap = $urandom_range(400000, 1000);
            configure(gap, $urandom_range(gap), 8'($urandom_range(40, 1)));
            run_random(100, 5, 15);
        end

        wait_idle();
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* sim.f */
design/mei_pkg.sv
design/mei_in_stage.sv
design/mei_core.sv
design/mei_out_stage.sv
design/manchester_edge_interval_receiver.sv
tb/manchester_edge_interval_receiver_tb.sv
